/* sv/wsre_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wsre_pkg;

    localparam int MAX_SECTORS = 32;
    localparam int NCHUNK      = (MAX_SECTORS + 1) / 2;
    localparam int CIDX_W      = $clog2(NCHUNK);
    localparam int CNT_W       = $clog2(NCHUNK + 1);
    localparam int TOT_W       = $clog2(MAX_SECTORS + 1);
    localparam int WIN_MAX     = 8;
    localparam logic [23:0] MAGIC_WORD = 24'h416F45;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_REPLY  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] REG_WINDOW   = 2'd0;
    localparam logic [1:0] REG_RETRY    = 2'd1;
    localparam logic [1:0] REG_READ_OP  = 2'd2;
    localparam logic [1:0] REG_WRITE_OP = 2'd3;

    typedef enum logic [2:0] {
        KIND_REQ     = 3'd0,
        KIND_CHUNK   = 3'd1,
        KIND_OK      = 3'd2,
        KIND_PROTO   = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_REPLY = 2'd1,
        CLS_TICK  = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic        is_write;
        logic [31:0] sector;
        logic [5:0]  total;
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [7:0]  count;
        logic        status_nz;
        logic        magic_ok;
        logic        pay_hdr;
        logic        pay_data;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         seq;
        logic [7:0]         cmd;
        logic [31:0]        sector;
        logic [1:0]         count;
        logic [CIDX_W-1:0]  idx;
    } result_t;

    typedef struct packed {
        logic             busy;
        logic [3:0]       outst;
        logic [CNT_W-1:0] remaining;
    } back_stat_t;

endpackage
`default_nettype wire

/* sv/wsre_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsre_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [159:0]    s_tdata,
    input  wire logic [1:0]      s_tuser,
    output logic                 q_valid,
    output wsre_pkg::item_t      q_item,
    input  wire logic            q_pop
);

    wsre_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    wsre_pkg::item_t in_item;
    logic       keep, push;

    always_comb begin
        in_item.cls       = (s_tuser == wsre_pkg::OP_START) ? wsre_pkg::CLS_START :
                            (s_tuser == wsre_pkg::OP_REPLY) ? wsre_pkg::CLS_REPLY :
                                                              wsre_pkg::CLS_TICK;
        in_item.is_write  = s_tdata[0];
        // Start items carry the first sector, replies the reply sector.
        in_item.sector    = (s_tuser == wsre_pkg::OP_START) ? s_tdata[32:1] : s_tdata[110:79];
        in_item.total     = s_tdata[38:33];
        in_item.seq       = s_tdata[70:63];
        in_item.cmd       = s_tdata[78:71];
        in_item.count     = s_tdata[118:111];
        in_item.status_nz = (s_tdata[150:119] != 32'd0);
        in_item.magic_ok  = (s_tdata[62:39] == wsre_pkg::MAGIC_WORD);
        in_item.pay_hdr   = (s_tdata[152:151] == 2'd0);
        in_item.pay_data  = (s_tdata[152:151] == 2'd1) || (s_tdata[152:151] == 2'd2);
        keep = (s_tuser == wsre_pkg::OP_START) || (s_tuser == wsre_pkg::OP_REPLY) ||
               (s_tuser == wsre_pkg::OP_TICK);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

/* sv/wsre_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsre_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              q_valid,
    input  wire wsre_pkg::item_t   q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    output wsre_pkg::result_t      out_data,
    output logic                   out_last,
    input  wire logic              out_ready,
    output wsre_pkg::back_stat_t   stat
);

    localparam int CI = wsre_pkg::CIDX_W;
    localparam int CW = wsre_pkg::CNT_W;
    localparam int TW = wsre_pkg::TOT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHUNK = 6'b000010,
        ST_POST  = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_END   = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]  win_reg;
    logic [7:0]  limit_reg, rd_op_reg, wr_op_reg;
    logic [7:0]  seq_ctr_reg, seq_ctr_next, first_seq_reg, first_seq_next;
    logic        busy_reg, busy_next, wmode_reg, wmode_next;
    logic [31:0] base_reg, base_next;
    logic [TW-1:0] tot_reg, tot_next;
    logic [wsre_pkg::NCHUNK-1:0] done_reg, done_next;
    logic [CI-1:0] ptr_reg, ptr_next, hit_reg, hit_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [3:0]  outst_reg, outst_next;
    logic [7:0]  retry_reg, retry_next;
    wsre_pkg::kind_t end_kind_reg, end_kind_next;
    logic        pend_valid_reg, pend_valid_next;
    wsre_pkg::result_t pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    wsre_pkg::result_t out_reg, out_next;

    logic [7:0]  opcode;
    logic [3:0]  win_eff;
    logic [CW-1:0] n_cur, n_start;
    logic [TW-1:0] tot_start;
    logic [TW:0] tot_inc;
    logic [7:0]  diff, retry_inc;
    logic [CI-1:0] ridx;
    logic        hit, out_free, can_put, produce;
    wsre_pkg::result_t new_res;

    function automatic logic [31:0] chunk_sector(input logic [31:0] base,
                                                 input logic [CI-1:0] idx);
        chunk_sector = base + 32'({idx, 1'b0});
    endfunction

    function automatic logic [1:0] chunk_len(input logic [TW-1:0] tot,
                                             input logic [CI-1:0] idx);
        chunk_len = ((TW+2)'(tot) >= (TW+2)'({idx, 1'b0}) + (TW+2)'(2)) ? 2'd2 : 2'd1;
    endfunction

    function automatic wsre_pkg::result_t chunk_res(input wsre_pkg::kind_t kind,
                                                   input logic [7:0] first_seq,
                                                   input logic [7:0] opc,
                                                   input logic [31:0] base,
                                                   input logic [TW-1:0] tot,
                                                   input logic [CI-1:0] idx);
        wsre_pkg::result_t r;
        r.kind   = kind;
        r.seq    = first_seq + 8'd1 + 8'(idx);
        r.cmd    = opc;
        r.sector = chunk_sector(base, idx);
        r.count  = chunk_len(tot, idx);
        r.idx    = idx;
        chunk_res = r;
    endfunction

    assign opcode  = wmode_reg ? wr_op_reg : rd_op_reg;
    assign win_eff = (win_reg == 4'd0) ? 4'd1 :
                     (win_reg > 4'(wsre_pkg::WIN_MAX)) ? 4'(wsre_pkg::WIN_MAX) : win_reg;
    assign tot_inc = (TW+1)'(tot_reg) + (TW+1)'(1);
    assign n_cur   = CW'(tot_inc[TW:1]);
    assign out_free = !out_valid_reg || out_ready;
    assign can_put  = !pend_valid_reg || out_free;
    assign retry_inc = (retry_reg == 8'hFF) ? 8'hFF : retry_reg + 8'd1;

    // Sequence numbers of a transfer are consecutive, so the reply seq names its chunk.
    assign diff = q_item.seq - first_seq_reg - 8'd1;
    assign ridx = diff[CI-1:0];
    assign hit  = (wmode_reg ? q_item.pay_hdr : q_item.pay_data) && q_item.magic_ok &&
                  (diff < 8'(n_cur)) && (q_item.cmd == opcode) &&
                  (q_item.sector == chunk_sector(base_reg, ridx)) &&
                  (q_item.count == {6'd0, chunk_len(tot_reg, ridx)});

    always_comb begin
        tot_start = (q_item.total > 6'(wsre_pkg::MAX_SECTORS)) ?
                    TW'(wsre_pkg::MAX_SECTORS) : TW'(q_item.total);
        n_start   = CW'(((TW+1)'(tot_start) + (TW+1)'(1)) >> 1);
    end

    always_comb begin
        state_next = state_reg;
        seq_ctr_next = seq_ctr_reg;
        first_seq_next = first_seq_reg;
        busy_next = busy_reg;
        wmode_next = wmode_reg;
        base_next = base_reg;
        tot_next = tot_reg;
        done_next = done_reg;
        ptr_next = ptr_reg;
        hit_next = hit_reg;
        rem_next = rem_reg;
        outst_next = outst_reg;
        retry_next = retry_reg;
        end_kind_next = end_kind_reg;
        q_pop = 1'b0;
        produce = 1'b0;
        new_res = '0;
        new_res.kind = end_kind_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_item.cls)
                        wsre_pkg::CLS_START: begin
                            if (!busy_reg) begin
                                wmode_next     = q_item.is_write;
                                base_next      = q_item.sector;
                                tot_next       = tot_start;
                                first_seq_next = seq_ctr_reg;
                                seq_ctr_next   = seq_ctr_reg + 8'(n_start);
                                done_next      = '0;
                                ptr_next       = '0;
                                rem_next       = n_start;
                                outst_next     = 4'd0;
                                retry_next     = 8'd0;
                                busy_next      = 1'b1;
                                if (n_start == '0) begin
                                    end_kind_next = wsre_pkg::KIND_OK;
                                    state_next    = ST_END;
                                end else begin
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        wsre_pkg::CLS_REPLY: begin
                            if (busy_reg) begin
                                state_next = ST_POST;
                                if (hit) begin
                                    retry_next = 8'd0;
                                    if (q_item.status_nz) begin
                                        end_kind_next = wsre_pkg::KIND_PROTO;
                                        state_next    = ST_END;
                                    end else if (!done_reg[ridx]) begin
                                        done_next[ridx] = 1'b1;
                                        if (rem_reg != '0) rem_next = rem_reg - CW'(1);
                                        if (outst_reg != 4'd0) outst_next = outst_reg - 4'd1;
                                        hit_next   = ridx;
                                        state_next = ST_CHUNK;
                                    end
                                end
                            end
                        end
                        wsre_pkg::CLS_TICK: begin
                            if (busy_reg) begin
                                if (outst_reg != 4'd0) outst_next = outst_reg - 4'd1;
                                state_next = ST_POST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHUNK: begin
                if (can_put) begin
                    produce    = 1'b1;
                    new_res    = chunk_res(wsre_pkg::KIND_CHUNK, first_seq_reg, opcode,
                                           base_reg, tot_reg, hit_reg);
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                retry_next = retry_inc;
                if (rem_reg == '0) begin
                    end_kind_next = wsre_pkg::KIND_OK;
                    state_next    = ST_END;
                end else if (retry_inc >= limit_reg) begin
                    end_kind_next = wsre_pkg::KIND_TIMEOUT;
                    state_next    = ST_END;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                // One chunk a cycle under the round-robin pointer, unless the output registers are full.
                if (outst_reg < win_eff && CW'(outst_reg) < rem_reg) begin
                    if (done_reg[ptr_reg] || can_put) begin
                        ptr_next = (CW'(ptr_reg) + CW'(1) == n_cur) ? '0 : ptr_reg + CI'(1);
                    end
                    if (!done_reg[ptr_reg] && can_put) begin
                        produce    = 1'b1;
                        new_res    = chunk_res(wsre_pkg::KIND_REQ, first_seq_reg, opcode,
                                               base_reg, tot_reg, ptr_reg);
                        outst_next = outst_reg + 4'd1;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_END: begin
                if (can_put) begin
                    produce    = 1'b1;
                    busy_next  = 1'b0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A result waits in the pending register until the next one, or the end
    // of the item, tells whether it is the last one.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (produce) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = new_res;
        end else if (state_reg == ST_FLUSH && pend_valid_reg && out_free) begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_reg        <= 4'd4;
            limit_reg      <= 8'd100;
            rd_op_reg      <= 8'd1;
            wr_op_reg      <= 8'd2;
            seq_ctr_reg    <= 8'd0;
            busy_reg       <= 1'b0;
            done_reg       <= '0;
            ptr_reg        <= '0;
            rem_reg        <= '0;
            outst_reg      <= 4'd0;
            retry_reg      <= 8'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            seq_ctr_reg    <= seq_ctr_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            ptr_reg        <= ptr_next;
            rem_reg        <= rem_next;
            outst_reg      <= outst_next;
            retry_reg      <= retry_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    wsre_pkg::REG_WINDOW:   win_reg   <= cfg_wdata[3:0];
                    wsre_pkg::REG_RETRY:    limit_reg <= cfg_wdata;
                    wsre_pkg::REG_READ_OP:  rd_op_reg <= cfg_wdata;
                    wsre_pkg::REG_WRITE_OP: wr_op_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        first_seq_reg <= first_seq_next;
        wmode_reg     <= wmode_next;
        base_reg      <= base_next;
        tot_reg       <= tot_next;
        hit_reg       <= hit_next;
        end_kind_reg  <= end_kind_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_last  = out_last_reg;
    assign stat.busy      = busy_reg;
    assign stat.outst     = outst_reg;
    assign stat.remaining = rem_reg;

endmodule
`default_nettype wire

/* sv/windowed_sector_request_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Splits a sector transfer of up to 32 sectors into chunk requests of up to two
// sectors and tracks replies over a window of outstanding requests, resending on
// timeout ticks. A front stage decodes input beats into a two-entry queue; a back-end
// sequencer handles one queued item at a time, looking at one chunk per cycle unless
// the output registers are full. Results leave through a pending and an output
// register; the final result of an item carries tlast. Configuration writes are
// taken on any cycle with cfg_wr_en high and must only be made while idle.
module windowed_sector_request_engine_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // is_write, first_sector, sector_total, reply_magic, reply_seq, reply_command,
    // reply_sector, reply_count, reply_status, reply_payload
    input  wire logic [159:0] s_tdata,
    // op
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // seq, command, sector, count, chunk_index
    output logic [55:0]       m_tdata,
    // kind
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    logic                 q_valid, q_pop;
    wsre_pkg::item_t      q_item;
    wsre_pkg::result_t    res;
    wsre_pkg::back_stat_t stat;

    wsre_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    wsre_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_data(res), .out_last(m_tlast), .out_ready(m_tready),
        .stat(stat)
    );

    assign m_tdata = {2'b00, 4'(res.idx), res.count, res.sector, res.cmd, res.seq};
    assign m_tuser = res.kind;

    a_outst_le_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        4'(stat.remaining) >= stat.outst || stat.remaining > 5'(15))
        else $error("outstanding requests exceed open chunks");

    a_outst_le_win: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.outst <= 4'(wsre_pkg::WIN_MAX))
        else $error("outstanding requests exceed the largest window");

    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stat.busy) |-> stat.outst == 4'd0)
        else $error("transfer started with requests outstanding");

endmodule
`default_nettype wire
